@@ rtl/imu_motion_and_step_detector_core_macros.svh @@
// ----------------------------------------------------------------------------
// IMU detector assertion macros
// Shared concurrent assertion wrappers, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef IMU_MOTION_AND_STEP_DETECTOR_CORE_MACROS_SVH
`define IMU_MOTION_AND_STEP_DETECTOR_CORE_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define IMD_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("imd assertion failed");
// next-cycle implication
`define IMD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("imd assertion failed");
`else
`define IMD_ASSERT(lbl, ante, cons)
`define IMD_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ rtl/imd_pkg.sv @@
// ----------------------------------------------------------------------------
// IMU detector package
// Widths, register indexes and shared types of the motion and step detector.
// ----------------------------------------------------------------------------
package imd_pkg;

  localparam int SAMPLE_BITS = 16;             // width of one axis sample
  localparam int AXES        = 3;              // axes per sensor
  localparam int LANES       = 2 * AXES;       // accel and gyro lanes
  localparam int SQ_W        = 2 * SAMPLE_BITS;
  localparam int MAG_W       = 32;             // reported magnitude width
  localparam int SUM_W       = (SQ_W + 2 > MAG_W) ? SQ_W + 2 : MAG_W + 1;
  localparam int TIME_W      = 32;
  localparam int MS_W        = 16;
  localparam int CNT_W       = 32;
  localparam int THR_W       = 32;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_ADDR_W  = 3;

  localparam int IN_FIELDS_W   = LANES * SAMPLE_BITS + TIME_W;
  localparam int IN_TDATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W  = 2 + CNT_W + 2 * MAG_W;
  localparam int OUT_TDATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_ACCEL_HIGH = 3'd0,
    CFG_ACCEL_LOW  = 3'd1,
    CFG_GYRO_HIGH  = 3'd2,
    CFG_STEP_LEVEL = 3'd3,
    CFG_HOLD_MS    = 3'd4,
    CFG_GAP_MS     = 3'd5
  } imd_cfg_idx_t;

  typedef logic [SQ_W-1:0] imd_sq_t;

  typedef struct packed {
    logic [THR_W-1:0] accel_high_sq;
    logic [THR_W-1:0] accel_low_sq;
    logic [THR_W-1:0] gyro_high_sq;
    logic [THR_W-1:0] step_level_sq;
    logic [MS_W-1:0]  motion_hold_ms;
    logic [MS_W-1:0]  step_gap_ms;
  } imd_cfg_t;

  // pipeline load strobes: lanes, sum stage, decision/output stage
  typedef struct packed {
    logic ld_a;
    logic ld_b;
    logic ld_c;
  } imd_pipe_ctl_t;

endpackage

@@ rtl/imd_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// IMU detector configuration registers
// Threshold and timing registers, written through a plain indexed port.
// ----------------------------------------------------------------------------
module imd_cfg_regs (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [imd_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [imd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output imd_pkg::imd_cfg_t                  cfg
);
  import imd_pkg::*;

  logic [THR_W-1:0] accel_high_r;
  logic [THR_W-1:0] accel_low_r;
  logic [THR_W-1:0] gyro_high_r;
  logic [THR_W-1:0] step_level_r;
  logic [MS_W-1:0]  hold_ms_r;
  logic [MS_W-1:0]  gap_ms_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accel_high_r <= THR_W'(355005891);
      accel_low_r  <= THR_W'(193944617);
      gyro_high_r  <= THR_W'(10725625);
      step_level_r <= THR_W'(603979776);
      hold_ms_r    <= MS_W'(2000);
      gap_ms_r     <= MS_W'(250);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_ACCEL_HIGH: accel_high_r <= cfg_wdata[THR_W-1:0];
        CFG_ACCEL_LOW:  accel_low_r  <= cfg_wdata[THR_W-1:0];
        CFG_GYRO_HIGH:  gyro_high_r  <= cfg_wdata[THR_W-1:0];
        CFG_STEP_LEVEL: step_level_r <= cfg_wdata[THR_W-1:0];
        CFG_HOLD_MS:    hold_ms_r    <= cfg_wdata[MS_W-1:0];
        CFG_GAP_MS:     gap_ms_r     <= cfg_wdata[MS_W-1:0];
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  always_comb begin
    cfg.accel_high_sq  = accel_high_r;
    cfg.accel_low_sq   = accel_low_r;
    cfg.gyro_high_sq   = gyro_high_r;
    cfg.step_level_sq  = step_level_r;
    cfg.motion_hold_ms = hold_ms_r;
    cfg.step_gap_ms    = gap_ms_r;
  end

endmodule

@@ rtl/imd_lane.sv @@
// ----------------------------------------------------------------------------
// IMU detector axis lane
// Absolute value and square of one signed axis sample, registered.
// ----------------------------------------------------------------------------
module imd_lane (
  input  logic                              clk,
  input  logic                              ld,
  input  logic [imd_pkg::SAMPLE_BITS-1:0]   sample,
  output imd_pkg::imd_sq_t                  sq
);
  import imd_pkg::*;

  logic [SAMPLE_BITS-1:0] mag;
  imd_sq_t                sq_r;
  imd_sq_t                sq_nxt;

  // most negative code maps to 2^(n-1), which still fits unsigned
  assign mag    = sample[SAMPLE_BITS-1] ? (~sample + SAMPLE_BITS'(1)) : sample;
  assign sq_nxt = SQ_W'(mag) * SQ_W'(mag);

  always_ff @(posedge clk) begin
    if (ld) begin
      sq_r <= sq_nxt;
    end
  end

  assign sq = sq_r;

endmodule

@@ rtl/imd_merge.sv @@
// ----------------------------------------------------------------------------
// IMU detector merge stage
// Sums lane squares, applies motion and step rules, holds the output word.
// ----------------------------------------------------------------------------
module imd_merge (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  imd_pkg::imd_pipe_ctl_t               ctl,
  input  imd_pkg::imd_cfg_t                    cfg,
  input  logic [imd_pkg::TIME_W-1:0]           time_in,
  input  imd_pkg::imd_sq_t [imd_pkg::AXES-1:0] acc_sq,
  input  imd_pkg::imd_sq_t [imd_pkg::AXES-1:0] gyr_sq,
  output logic                                 moving,
  output logic                                 step_now,
  output logic [imd_pkg::CNT_W-1:0]            step_total,
  output logic [imd_pkg::MAG_W-1:0]            accel_mag_sq,
  output logic [imd_pkg::MAG_W-1:0]            gyro_mag_sq
);
  import imd_pkg::*;

  // stage A/B payload
  logic [TIME_W-1:0] time_a_r;
  logic [TIME_W-1:0] time_b_r;
  logic [SUM_W-1:0]  acc_b_r;
  logic [SUM_W-1:0]  gyr_b_r;
  logic [SUM_W-1:0]  acc_b_nxt;
  logic [SUM_W-1:0]  gyr_b_nxt;

  // detector state
  logic              moving_r, moving_nxt;
  logic [TIME_W-1:0] start_r, start_nxt;
  logic              was_above_r, was_above_nxt;
  logic [TIME_W-1:0] last_step_r, last_step_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  // output payload
  logic              step_r, step_nxt;
  logic [MAG_W-1:0]  acc_out_r, acc_out_nxt;
  logic [MAG_W-1:0]  gyr_out_r, gyr_out_nxt;

  logic              motion_hit;
  logic              above;
  logic [TIME_W-1:0] hold_dt;
  logic [TIME_W-1:0] gap_dt;

  always_comb begin
    acc_b_nxt = '0;
    gyr_b_nxt = '0;
    for (int i = 0; i < AXES; i++) begin
      acc_b_nxt = acc_b_nxt + SUM_W'(acc_sq[i]);
      gyr_b_nxt = gyr_b_nxt + SUM_W'(gyr_sq[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_a) begin
      time_a_r <= time_in;
    end
    if (ctl.ld_b) begin
      time_b_r <= time_a_r;
      acc_b_r  <= acc_b_nxt;
      gyr_b_r  <= gyr_b_nxt;
    end
  end

  always_comb begin
    motion_hit = (acc_b_r > SUM_W'(cfg.accel_high_sq)) ||
                 (acc_b_r < SUM_W'(cfg.accel_low_sq))  ||
                 (gyr_b_r > SUM_W'(cfg.gyro_high_sq));
    above      = acc_b_r > SUM_W'(cfg.step_level_sq);
    hold_dt    = time_b_r - start_r;       // wraps mod 2^32
    gap_dt     = time_b_r - last_step_r;

    moving_nxt    = moving_r;
    start_nxt     = start_r;
    count_nxt     = count_r;
    last_step_nxt = last_step_r;
    was_above_nxt = above;

    // onset time is latched only on entry, not refreshed while moving
    if (motion_hit) begin
      if (!moving_r) begin
        moving_nxt = 1'b1;
        start_nxt  = time_b_r;
      end
    end else if (moving_r && (hold_dt > TIME_W'(cfg.motion_hold_ms))) begin
      moving_nxt = 1'b0;
    end

    step_nxt = above && !was_above_r && (gap_dt > TIME_W'(cfg.step_gap_ms));
    if (step_nxt) begin
      count_nxt     = count_r + CNT_W'(1);
      last_step_nxt = time_b_r;
    end

    acc_out_nxt = (|acc_b_r[SUM_W-1:MAG_W]) ? '1 : acc_b_r[MAG_W-1:0];
    gyr_out_nxt = (|gyr_b_r[SUM_W-1:MAG_W]) ? '1 : gyr_b_r[MAG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      moving_r    <= 1'b0;
      start_r     <= '0;
      was_above_r <= 1'b0;
      last_step_r <= '0;
      count_r     <= '0;
    end else if (ctl.ld_c) begin
      moving_r    <= moving_nxt;
      start_r     <= start_nxt;
      was_above_r <= was_above_nxt;
      last_step_r <= last_step_nxt;
      count_r     <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_c) begin
      step_r    <= step_nxt;
      acc_out_r <= acc_out_nxt;
      gyr_out_r <= gyr_out_nxt;
    end
  end

  assign moving       = moving_r;
  assign step_now     = step_r;
  assign step_total   = count_r;
  assign accel_mag_sq = acc_out_r;
  assign gyro_mag_sq  = gyr_out_r;

endmodule

@@ rtl/imu_motion_and_step_detector_core.sv @@
// ----------------------------------------------------------------------------
// IMU motion and step detector core: six multiplier lanes, sum, decision
// Pipeline stages in to out: lane square, magnitude sum, decision/output.
// Throughput one word per cycle; each pipe stage stalls only when downstream full.
// Sync active-low reset clears valids, detector state and loads default registers.
// ----------------------------------------------------------------------------
`include "imu_motion_and_step_detector_core_macros.svh"

module imu_motion_and_step_detector_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // in_tdata: accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z, time_ms
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [imd_pkg::IN_TDATA_W-1:0]       in_tdata,
  // out_tdata: moving, step_now, step_total, accel_mag_sq, gyro_mag_sq, zero pad
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [imd_pkg::OUT_TDATA_W-1:0]      out_tdata,
  input  logic                                 cfg_we,
  input  logic [imd_pkg::CFG_ADDR_W-1:0]       cfg_addr,
  input  logic [imd_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
  import imd_pkg::*;

  imd_cfg_t      cfg;
  imd_pipe_ctl_t ctl;

  logic va_r, vb_r, vc_r;
  logic va_nxt, vb_nxt, vc_nxt;
  logic ready_b, ready_c;

  logic [LANES-1:0][SAMPLE_BITS-1:0] axis;
  imd_sq_t [LANES-1:0]               lane_sq;
  logic [TIME_W-1:0]                 time_in;

  logic              moving;
  logic              step_now;
  logic [CNT_W-1:0]  step_total;
  logic [MAG_W-1:0]  accel_mag_sq;
  logic [MAG_W-1:0]  gyro_mag_sq;

  // handshake chain, output register back to input
  always_comb begin
    ready_c    = !vc_r || out_tready;
    ready_b    = !vb_r || ready_c;
    in_tready  = !va_r || ready_b;
    ctl.ld_a   = in_tvalid && in_tready;
    ctl.ld_b   = va_r && ready_b;
    ctl.ld_c   = vb_r && ready_c;
    va_nxt     = ctl.ld_a ? 1'b1 : (ctl.ld_b ? 1'b0 : va_r);
    vb_nxt     = ctl.ld_b ? 1'b1 : (ctl.ld_c ? 1'b0 : vb_r);
    vc_nxt     = ctl.ld_c ? 1'b1 : (out_tready ? 1'b0 : vc_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else begin
      va_r <= va_nxt;
      vb_r <= vb_nxt;
      vc_r <= vc_nxt;
    end
  end

  assign out_tvalid = vc_r;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      axis[i] = in_tdata[i*SAMPLE_BITS +: SAMPLE_BITS];
    end
    time_in = in_tdata[LANES*SAMPLE_BITS +: TIME_W];
  end

  imd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // lanes 0..2 accel, 3..5 gyro
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    imd_lane u_lane (
      .clk    (clk),
      .ld     (ctl.ld_a),
      .sample (axis[g]),
      .sq     (lane_sq[g])
    );
  end

  imd_merge u_merge (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (ctl),
    .cfg          (cfg),
    .time_in      (time_in),
    .acc_sq       (lane_sq[AXES-1:0]),
    .gyr_sq       (lane_sq[LANES-1:AXES]),
    .moving       (moving),
    .step_now     (step_now),
    .step_total   (step_total),
    .accel_mag_sq (accel_mag_sq),
    .gyro_mag_sq  (gyro_mag_sq)
  );

  assign out_tdata = {(OUT_TDATA_W - OUT_FIELDS_W)'(0),
                      gyro_mag_sq, accel_mag_sq, step_total, step_now, moving};

  `IMD_ASSERT_NEXT(a_load_shows_word, ctl.ld_c, out_tvalid)
  `IMD_ASSERT_NEXT(a_stall_keeps_b, vb_r && !ready_c, vb_r)
  `IMD_ASSERT_NEXT(a_accept_fills_a, ctl.ld_a, va_r)
  `IMD_ASSERT(a_empty_front_ready, !va_r, in_tready)

endmodule
